>>> rtl/assert_macros.svh
// Assertion macros used by the checker file of the project.
// Each macro expands to one labeled concurrent assertion that reports through $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that is checked during reset as well.
`define ASSERT_NXT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/itp_pkg.sv
// Package of the infix-to-postfix converter: sizes, character and status codes, token types.
// Depends on nothing; every RTL file of the block refers to it by scoped names.
package itp_pkg;

   // Operator stack size and the widths that follow from it.
   localparam int STACK_DEPTH = 32;
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

   // Token queue between the classifier and the stack engine.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // ASCII characters with a meaning of their own.
   localparam logic [7:0] CH_OPEN  = 8'h28;
   localparam logic [7:0] CH_CLOSE = 8'h29;
   localparam logic [7:0] CH_ADD   = 8'h2B;
   localparam logic [7:0] CH_SUB   = 8'h2D;
   localparam logic [7:0] CH_MUL   = 8'h2A;
   localparam logic [7:0] CH_DIV   = 8'h2F;
   localparam logic [7:0] CH_MOD   = 8'h25;
   localparam logic [7:0] CH_NONE  = 8'h00;

   // Codes kept on the operator stack.
   typedef logic [2:0] op_code_type;
   localparam op_code_type CODE_OPEN = 3'd0;
   localparam op_code_type CODE_ADD  = 3'd1;
   localparam op_code_type CODE_SUB  = 3'd2;
   localparam op_code_type CODE_MUL  = 3'd3;
   localparam op_code_type CODE_DIV  = 3'd4;
   localparam op_code_type CODE_MOD  = 3'd5;

   // Result status codes.
   typedef logic [2:0] status_type;
   localparam status_type ST_SYMBOL          = 3'd0;
   localparam status_type ST_DONE            = 3'd1;
   localparam status_type ST_BADCHAR         = 3'd2;
   localparam status_type ST_UNMATCHED_CLOSE = 3'd3;
   localparam status_type ST_OVERFLOW        = 3'd4;
   localparam status_type ST_UNMATCHED_OPEN  = 3'd5;

   // Token kinds produced by the classifier.
   typedef logic [2:0] tok_kind_type;
   localparam tok_kind_type TK_OPERAND = 3'd0;
   localparam tok_kind_type TK_OPEN    = 3'd1;
   localparam tok_kind_type TK_CLOSE   = 3'd2;
   localparam tok_kind_type TK_OPER    = 3'd3;
   localparam tok_kind_type TK_BAD     = 3'd4;
   localparam tok_kind_type TK_END     = 3'd5;

   typedef struct packed {
      tok_kind_type kind;
      logic [7:0]   symbol;
      op_code_type  code;
   } token_type;

   // Head of the token queue as seen by the stack engine.
   typedef struct packed {
      logic      valid;
      token_type tok;
   } head_type;

   typedef struct packed {
      logic [7:0] char_out;
      status_type status;
      logic       last;
   } result_type;

   function automatic logic [7:0] code_char(input op_code_type code);
      logic [7:0] ch;
      case (code)
         CODE_OPEN: ch = CH_OPEN;
         CODE_ADD:  ch = CH_ADD;
         CODE_SUB:  ch = CH_SUB;
         CODE_MUL:  ch = CH_MUL;
         CODE_DIV:  ch = CH_DIV;
         CODE_MOD:  ch = CH_MOD;
         default:   ch = CH_NONE;
      endcase
      return ch;
   endfunction

   // Multiplicative operators rank above additive ones.
   function automatic logic op_prio(input op_code_type code);
      return (code >= CODE_MUL);
   endfunction

endpackage

>>> rtl/infix_to_postfix_converter_top.sv
// Top level of the infix-to-postfix converter: classifier, token queue and stack engine.
// Depends on itp_pkg, itp_front, itp_queue and itp_back.
//
//   Channel   Direction  Handshake             Payload
//   req_      in         req_valid/req_stall   req_char_in[7:0], req_end_of_expr
//   rsp_      out        rsp_valid/rsp_stall   rsp_char_out[7:0], rsp_status[2:0],
//                                              rsp_last_of_run
//
// An operand, a bad character or an open paren is handled at once; an operator first pops
// the stacked operators of equal or higher rank, a close paren pops down to its open paren,
// and an end word pops all. The pace is set by the single read port of the operator stack.
// Reset is synchronous and active high; it empties the queue, the stack count and the
// result stages. The front accepts words while the four-entry token queue has room, and a
// stall on the result side stops only the stack engine once its hold and output stages fill.
module infix_to_postfix_converter_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_char_in,
   input  logic       req_end_of_expr,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_char_out,
   output logic [2:0] rsp_status,
   output logic       rsp_last_of_run
);

   // Tokens flow from the classifier into the queue, and from the queue head into the engine.
   logic               q_full;
   logic               q_push;
   logic               q_pop;
   itp_pkg::token_type q_push_tok;
   itp_pkg::head_type  q_head;

   // The classifier turns each accepted word into a token: operand, paren, operator,
   // bad character or end marker. It never waits on the stack.
   itp_front u_front (
      .req_valid       (req_valid),
      .req_char_in     (req_char_in),
      .req_end_of_expr (req_end_of_expr),
      .req_stall       (req_stall),
      .q_full          (q_full),
      .push            (q_push),
      .push_tok        (q_push_tok)
   );

   // The queue lets the front keep taking words while the engine is busy popping.
   itp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_tok (q_push_tok),
      .full     (q_full),
      .pop      (q_pop),
      .head     (q_head)
   );

   // The engine owns the operator stack, the error skip flag and the result registers.
   // It retires the queue head only when the token's work is complete.
   itp_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (q_head),
      .pop             (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_char_out    (rsp_char_out),
      .rsp_status      (rsp_status),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

>>> rtl/itp_front.sv
// Front end of the converter: accepts input words and classifies them into tokens.
// Depends on itp_pkg; feeds itp_queue.
module itp_front (
   input  logic               req_valid,
   input  logic [7:0]         req_char_in,
   input  logic               req_end_of_expr,
   output logic               req_stall,
   input  logic               q_full,
   output logic               push,
   output itp_pkg::token_type push_tok
);

   logic is_alnum;

   always_comb begin
      is_alnum = ((req_char_in >= 8'h30) && (req_char_in <= 8'h39)) ||
                 ((req_char_in >= 8'h41) && (req_char_in <= 8'h5A)) ||
                 ((req_char_in >= 8'h61) && (req_char_in <= 8'h7A));

      push_tok.symbol = req_char_in;
      push_tok.code   = itp_pkg::CODE_OPEN;
      push_tok.kind   = itp_pkg::TK_BAD;
      if (req_end_of_expr) begin
         push_tok.kind = itp_pkg::TK_END;
      end else begin
         case (req_char_in)
            itp_pkg::CH_OPEN: begin
               push_tok.kind = itp_pkg::TK_OPEN;
            end
            itp_pkg::CH_CLOSE: begin
               push_tok.kind = itp_pkg::TK_CLOSE;
            end
            itp_pkg::CH_ADD: begin
               push_tok.kind = itp_pkg::TK_OPER;
               push_tok.code = itp_pkg::CODE_ADD;
            end
            itp_pkg::CH_SUB: begin
               push_tok.kind = itp_pkg::TK_OPER;
               push_tok.code = itp_pkg::CODE_SUB;
            end
            itp_pkg::CH_MUL: begin
               push_tok.kind = itp_pkg::TK_OPER;
               push_tok.code = itp_pkg::CODE_MUL;
            end
            itp_pkg::CH_DIV: begin
               push_tok.kind = itp_pkg::TK_OPER;
               push_tok.code = itp_pkg::CODE_DIV;
            end
            itp_pkg::CH_MOD: begin
               push_tok.kind = itp_pkg::TK_OPER;
               push_tok.code = itp_pkg::CODE_MOD;
            end
            default: begin
               push_tok.kind = is_alnum ? itp_pkg::TK_OPERAND : itp_pkg::TK_BAD;
            end
         endcase
      end
   end

   assign req_stall = q_full;
   assign push      = req_valid && !q_full;

endmodule

>>> rtl/itp_queue.sv
// Short token queue that decouples the classifier from the stack engine.
// Depends on itp_pkg.
module itp_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  itp_pkg::token_type push_tok,
   output logic               full,
   input  logic               pop,
   output itp_pkg::head_type  head
);

   itp_pkg::token_type              entries_ff [itp_pkg::QUEUE_DEPTH];
   logic [itp_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [itp_pkg::QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [itp_pkg::QCNT_W-1:0]      cnt_ff, cnt_in;
   logic                            do_pop;

   always_comb begin
      do_pop    = pop && (cnt_ff != '0);
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == itp_pkg::QPTR_W'(itp_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == itp_pkg::QPTR_W'(itp_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!push && do_pop) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_tok;
      end
   end

   assign full       = (cnt_ff == itp_pkg::QCNT_W'(itp_pkg::QUEUE_DEPTH));
   assign head.valid = (cnt_ff != '0);
   assign head.tok   = entries_ff[rd_ptr_ff];

endmodule

>>> rtl/itp_back.sv
// Stack engine of the converter: runs tokens against the operator stack and emits results.
// Depends on itp_pkg; takes tokens from itp_queue.
module itp_back (
   input  logic              clock,
   input  logic              reset,
   input  itp_pkg::head_type head,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_char_out,
   output logic [2:0]        rsp_status,
   output logic              rsp_last_of_run
);

   // Operator stack; the entry below the count is read ahead into top_rd_ff.
   itp_pkg::op_code_type            stack_mem [itp_pkg::STACK_DEPTH];
   itp_pkg::op_code_type            top_rd_ff;
   itp_pkg::op_code_type            byp_code_ff;
   logic                            byp_ff;
   logic [itp_pkg::ADDR_W-1:0]      rd_addr;

   logic [itp_pkg::CNT_W-1:0]       cnt_ff, cnt_in;
   logic                            skip_ff, skip_in;
   logic                            open_left_ff, open_left_in;

   // Hold stage keeps the newest result until it is known whether it ends the run.
   logic                            hold_v_ff, hold_v_in;
   itp_pkg::result_type             hold_ff, hold_in;
   logic                            out_v_ff, out_v_in;
   itp_pkg::result_type             out_ff, out_in;

   itp_pkg::op_code_type            top;
   itp_pkg::token_type              tok;
   itp_pkg::result_type             gen_res;
   logic                            gen;
   logic                            push;
   logic                            step;
   logic                            out_free;
   logic                            stk_empty;
   logic                            stk_full;
   logic                            top_open;
   logic                            item_done;

   always_comb begin
      tok       = head.tok;
      top       = byp_ff ? byp_code_ff : top_rd_ff;
      out_free  = !out_v_ff || !rsp_stall;
      stk_empty = (cnt_ff == '0);
      stk_full  = (cnt_ff == itp_pkg::CNT_W'(itp_pkg::STACK_DEPTH));
      top_open  = (top == itp_pkg::CODE_OPEN);
      step      = head.valid && (!hold_v_ff || out_free);

      gen          = 1'b0;
      gen_res      = '0;
      pop          = 1'b0;
      push         = 1'b0;
      cnt_in       = cnt_ff;
      skip_in      = skip_ff;
      open_left_in = open_left_ff;

      if (step) begin
         if (skip_ff) begin
            pop = 1'b1;
            if (tok.kind == itp_pkg::TK_END) begin
               skip_in = 1'b0;
               cnt_in  = '0;
            end
         end else begin
            case (tok.kind)
               itp_pkg::TK_OPERAND: begin
                  gen     = 1'b1;
                  gen_res = '{tok.symbol, itp_pkg::ST_SYMBOL, 1'b1};
                  pop     = 1'b1;
               end
               itp_pkg::TK_BAD: begin
                  gen     = 1'b1;
                  gen_res = '{itp_pkg::CH_NONE, itp_pkg::ST_BADCHAR, 1'b1};
                  cnt_in  = '0;
                  skip_in = 1'b1;
                  pop     = 1'b1;
               end
               itp_pkg::TK_OPEN: begin
                  pop = 1'b1;
                  if (stk_full) begin
                     gen     = 1'b1;
                     gen_res = '{itp_pkg::CH_NONE, itp_pkg::ST_OVERFLOW, 1'b1};
                     cnt_in  = '0;
                     skip_in = 1'b1;
                  end else begin
                     push   = 1'b1;
                     cnt_in = cnt_ff + 1'b1;
                  end
               end
               itp_pkg::TK_CLOSE: begin
                  if (!stk_empty && !top_open) begin
                     gen     = 1'b1;
                     gen_res = '{itp_pkg::code_char(top), itp_pkg::ST_SYMBOL, 1'b0};
                     cnt_in  = cnt_ff - 1'b1;
                  end else if (stk_empty) begin
                     gen     = 1'b1;
                     gen_res = '{itp_pkg::CH_NONE, itp_pkg::ST_UNMATCHED_CLOSE, 1'b1};
                     skip_in = 1'b1;
                     pop     = 1'b1;
                  end else begin
                     cnt_in = cnt_ff - 1'b1;
                     pop    = 1'b1;
                  end
               end
               itp_pkg::TK_OPER: begin
                  if (!stk_empty && !top_open &&
                      (itp_pkg::op_prio(top) >= itp_pkg::op_prio(tok.code))) begin
                     gen     = 1'b1;
                     gen_res = '{itp_pkg::code_char(top), itp_pkg::ST_SYMBOL, 1'b0};
                     cnt_in  = cnt_ff - 1'b1;
                  end else if (stk_full) begin
                     gen     = 1'b1;
                     gen_res = '{itp_pkg::CH_NONE, itp_pkg::ST_OVERFLOW, 1'b1};
                     cnt_in  = '0;
                     skip_in = 1'b1;
                     pop     = 1'b1;
                  end else begin
                     push   = 1'b1;
                     cnt_in = cnt_ff + 1'b1;
                     pop    = 1'b1;
                  end
               end
               itp_pkg::TK_END: begin
                  if (!stk_empty) begin
                     cnt_in = cnt_ff - 1'b1;
                     if (top_open) begin
                        open_left_in = 1'b1;
                     end else begin
                        gen     = 1'b1;
                        gen_res = '{itp_pkg::code_char(top), itp_pkg::ST_SYMBOL, 1'b0};
                     end
                  end else begin
                     gen          = 1'b1;
                     gen_res      = '{itp_pkg::CH_NONE,
                                      open_left_ff ? itp_pkg::ST_UNMATCHED_OPEN
                                                   : itp_pkg::ST_DONE,
                                      1'b1};
                     open_left_in = 1'b0;
                     pop          = 1'b1;
                  end
               end
               default: begin
                  pop = 1'b1;
               end
            endcase
         end
      end

      item_done = pop && !gen;
      rd_addr   = (cnt_in == '0) ? '0 : itp_pkg::ADDR_W'(cnt_in - 1'b1);

      hold_v_in = hold_v_ff;
      hold_in   = hold_ff;
      out_v_in  = out_v_ff && rsp_stall;
      out_in    = out_ff;
      if (gen) begin
         if (hold_v_ff) begin
            out_v_in = 1'b1;
            out_in   = hold_ff;
         end
         hold_v_in = 1'b1;
         hold_in   = gen_res;
      end else if (hold_v_ff && hold_ff.last && out_free) begin
         out_v_in  = 1'b1;
         out_in    = hold_ff;
         hold_v_in = 1'b0;
      end else if (item_done && hold_v_ff) begin
         hold_in.last = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         skip_ff      <= 1'b0;
         open_left_ff <= 1'b0;
         byp_ff       <= 1'b0;
         hold_v_ff    <= 1'b0;
         out_v_ff     <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         skip_ff      <= skip_in;
         open_left_ff <= open_left_in;
         byp_ff       <= push;
         hold_v_ff    <= hold_v_in;
         out_v_ff     <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         stack_mem[cnt_ff[itp_pkg::ADDR_W-1:0]] <= tok.code;
      end
      top_rd_ff   <= stack_mem[rd_addr];
      byp_code_ff <= tok.code;
      hold_ff     <= hold_in;
      out_ff      <= out_in;
   end

   assign rsp_valid       = out_v_ff;
   assign rsp_char_out    = out_ff.char_out;
   assign rsp_status      = out_ff.status;
   assign rsp_last_of_run = out_ff.last;

endmodule

>>> rtl/itp_checker.sv
// Port-level checker for the infix-to-postfix converter, bound to the top level.
// Depends on assert_macros.svh and on itp_pkg for the status codes.
`include "assert_macros.svh"

module itp_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_char_out,
   input logic [2:0] rsp_status,
   input logic       rsp_last_of_run
);

   // A stalled result stays put.
   `ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_char_out) && $stable(rsp_status) && $stable(rsp_last_of_run), "stalled result changed")

   // Status-only results carry no character.
   `ASSERT_IMP(a_status_no_char, clock, reset, rsp_valid && (rsp_status != itp_pkg::ST_SYMBOL), rsp_char_out == itp_pkg::CH_NONE, "status result carries a character")

   // A status result always closes the run of its input word.
   `ASSERT_IMP(a_status_last, clock, reset, rsp_valid && (rsp_status != itp_pkg::ST_SYMBOL), rsp_last_of_run, "status result not marked last")

   // Only the six defined status codes appear.
   `ASSERT_IMP(a_status_range, clock, reset, rsp_valid, rsp_status <= itp_pkg::ST_UNMATCHED_OPEN, "undefined status code")

   // Reset leaves the result channel empty.
   `ASSERT_NXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid, "result valid right after reset")

endmodule

bind infix_to_postfix_converter_top itp_checker u_itp_checker (.*);
